// ===== rtl/core/stq_pkg.sv =====
// ----------------------------------------------------------------------------
// stq_pkg
// Types and constants for the sorted timeout queue: request and result
// payloads, list entry, controller states, command and status groups.
// ----------------------------------------------------------------------------
package stq_pkg;

    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic signed [15:0] delay_secs;
        logic [31:0]        tag;
        logic               has_action;
    } stq_req_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] tag_res;
        logic        insert_failed;
        logic        pending_present;
        logic [31:0] next_delay;
        logic        last;
    } stq_res_t;

    typedef struct packed {
        logic [31:0] expiry;
        logic [31:0] tag;
        logic        action;
    } stq_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_SERVICE,
        ST_STATUS
    } stq_state_t;

    typedef struct packed {
        logic load_in;
        logic do_insert;
        logic do_pop;
        logic load_report;
        logic load_status;
    } stq_cmd_t;

    typedef struct packed {
        logic full;
        logic head_due;
        logic head_action;
        logic out_free;
    } stq_status_t;

endpackage

// ===== rtl/core/sorted_timeout_queue_top.sv =====
// An add passes through insert, expiry service (one pop per expired entry) and
// the closing status; a tick skips insert, and a failed add goes straight to status.
// A new request is accepted only once the closing status of the previous one has
// been loaded into the result register.
// Reports and the status wait on out_ready through the result register.
// Reset: list empty, seconds counter zero, no result pending.
// ----------------------------------------------------------------------------
// sorted_timeout_queue_top
// Bounded timeout list sorted by expiry second with a running seconds
// counter; reports expired entries with an action, and a closing status per request.
// ----------------------------------------------------------------------------
module sorted_timeout_queue_top #(
    parameter int SLOTS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  stq_pkg::stq_req_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output stq_pkg::stq_res_t out_data
);

    stq_pkg::stq_cmd_t    cmd;
    stq_pkg::stq_status_t status;

    stq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req_type (in_data.req_type),
        .status   (status),
        .cmd      (cmd)
    );

    stq_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== rtl/core/stq_ctrl.sv =====
// ----------------------------------------------------------------------------
// stq_ctrl
// Controller: accepts a request, sequences insert, expiry service and the
// closing status result.
// ----------------------------------------------------------------------------
module stq_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                req_type,
    input  stq_pkg::stq_status_t status,
    output stq_pkg::stq_cmd_t    cmd
);

    stq_pkg::stq_state_t state_reg;
    stq_pkg::stq_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            stq_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (req_type == stq_pkg::REQ_TICK)
                    begin
                        state_next = stq_pkg::ST_SERVICE;
                    end
                    else if (status.full)
                    begin
                        state_next = stq_pkg::ST_STATUS;
                    end
                    else
                    begin
                        state_next = stq_pkg::ST_INSERT;
                    end
                end
            end
            stq_pkg::ST_INSERT:
            begin
                state_next = stq_pkg::ST_SERVICE;
            end
            stq_pkg::ST_SERVICE:
            begin
                if (!status.head_due)
                begin
                    state_next = stq_pkg::ST_STATUS;
                end
            end
            stq_pkg::ST_STATUS:
            begin
                if (status.out_free)
                begin
                    state_next = stq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = stq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            stq_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            stq_pkg::ST_INSERT:
            begin
                cmd.do_insert = 1'b1;
            end
            stq_pkg::ST_SERVICE:
            begin
                if (status.head_due)
                begin
                    if (!status.head_action)
                    begin
                        cmd.do_pop = 1'b1;
                    end
                    else if (status.out_free)
                    begin
                        cmd.do_pop      = 1'b1;
                        cmd.load_report = 1'b1;
                    end
                end
            end
            stq_pkg::ST_STATUS:
            begin
                cmd.load_status = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/core/stq_datapath.sv =====
// ----------------------------------------------------------------------------
// stq_datapath
// Sorted entry list, seconds counter, insert/pop logic and result register.
// ----------------------------------------------------------------------------
module stq_datapath #(
    parameter int SLOTS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  stq_pkg::stq_req_t    in_data,
    input  stq_pkg::stq_cmd_t    cmd,
    output stq_pkg::stq_status_t status,
    output logic                 out_valid,
    input  logic                 out_ready,
    output stq_pkg::stq_res_t    out_data
);

    localparam int CNT_W = $clog2(SLOTS + 1);

    stq_pkg::stq_entry_t entry_reg  [SLOTS];
    stq_pkg::stq_entry_t entry_next [SLOTS];
    logic [CNT_W-1:0]    count_reg;
    logic [31:0]         now_reg;
    logic [31:0]         when_reg;
    logic [31:0]         tag_reg;
    logic                action_reg;
    logic                fail_reg;
    logic                out_valid_reg;
    stq_pkg::stq_res_t   out_reg;

    logic [SLOTS-1:0]    later;
    logic [31:0]         delay_ext;
    logic                full;
    stq_pkg::stq_entry_t new_entry;

    assign full      = (count_reg == CNT_W'(SLOTS));
    assign delay_ext = in_data.delay_secs[15] ? 32'd0 : {16'd0, in_data.delay_secs};
    assign new_entry = '{expiry: when_reg, tag: tag_reg, action: action_reg};

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            later[i] = (CNT_W'(i) < count_reg) && (when_reg > entry_reg[i].expiry);
        end
    end

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            entry_next[i] = entry_reg[i];
        end
        if (cmd.do_insert)
        begin
            if (!later[0])
            begin
                entry_next[0] = new_entry;
            end
            for (int i = 1; i < SLOTS; i++)
            begin
                if (!later[i])
                begin
                    entry_next[i] = later[i-1] ? new_entry : entry_reg[i-1];
                end
            end
        end
        else if (cmd.do_pop)
        begin
            for (int i = 0; i < SLOTS - 1; i++)
            begin
                entry_next[i] = entry_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            entry_reg[i] <= entry_next[i];
        end
        if (cmd.load_in)
        begin
            when_reg   <= now_reg + delay_ext;
            tag_reg    <= in_data.tag;
            action_reg <= in_data.has_action;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            now_reg   <= '0;
            fail_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load_in)
            begin
                fail_reg <= (in_data.req_type == stq_pkg::REQ_ADD) && full;
                if (in_data.req_type == stq_pkg::REQ_TICK)
                begin
                    now_reg <= now_reg + 32'd1;
                end
            end
            if (cmd.do_insert)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.do_pop)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_report || cmd.load_status)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_report)
        begin
            out_reg <= '{kind: stq_pkg::KIND_REPORT, tag_res: entry_reg[0].tag,
                         insert_failed: 1'b0, pending_present: 1'b0,
                         next_delay: 32'd0, last: 1'b0};
        end
        else if (cmd.load_status)
        begin
            out_reg <= '{kind: stq_pkg::KIND_STATUS, tag_res: 32'd0,
                         insert_failed: fail_reg,
                         pending_present: (count_reg != '0),
                         next_delay: (count_reg != '0) ?
                                     (entry_reg[0].expiry - now_reg) : 32'd0,
                         last: 1'b1};
        end
    end

    assign status.full        = full;
    assign status.head_due    = (count_reg != '0) && (entry_reg[0].expiry <= now_reg);
    assign status.head_action = entry_reg[0].action;
    assign status.out_free    = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timeout queue testbench
// Drives add and tick requests through the valid/ready request channel while
// an in-bench copy of the timeout list predicts every expiry report and the
// closing status. A short directed table fills the list, overflows it and
// walks ties and silent drops; random traffic follows with both sides idling.
// ----------------------------------------------------------------------------
module testbench;

    localparam int SLOTS       = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int RAND_REQS   = 480;

    typedef struct {
        stq_pkg::stq_req_t rq;
        bit                typed;
        stq_pkg::stq_res_t st;
    } plan_row_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    stq_pkg::stq_req_t in_data;
    logic              out_valid;
    logic              out_ready;
    stq_pkg::stq_res_t out_data;

    // in-bench copy of the timeout list
    logic [31:0] lst_exp [SLOTS];
    logic [31:0] lst_tag [SLOTS];
    logic        lst_act [SLOTS];
    int          lst_cnt;
    logic [31:0] secs;

    stq_pkg::stq_res_t step_out [$];
    stq_pkg::stq_res_t awaited_results [$];
    plan_row_t         directed_rows [$];

    int errors;
    int idle_cycles;
    bit steady;

    sorted_timeout_queue_top #(
        .SLOTS(SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic stq_pkg::stq_req_t mk_req(logic rt, logic [15:0] d, logic [31:0] t,
                                                 logic a);
        stq_pkg::stq_req_t r;
        r.req_type   = rt;
        r.delay_secs = d;
        r.tag        = t;
        r.has_action = a;
        return r;
    endfunction

    function automatic stq_pkg::stq_res_t closing(logic fail, logic pend, logic [31:0] nd);
        stq_pkg::stq_res_t r;
        r                 = '0;
        r.kind            = stq_pkg::KIND_STATUS;
        r.insert_failed   = fail;
        r.pending_present = pend;
        r.next_delay      = nd;
        r.last            = 1'b1;
        return r;
    endfunction

    // insert or advance time, then expire due entries from the head
    function automatic void predict_timeouts(stq_pkg::stq_req_t rq);
        logic [31:0]       when_s;
        int                pos;
        bit                failed;
        stq_pkg::stq_res_t r;
        failed = 1'b0;
        step_out.delete();
        if (rq.req_type == stq_pkg::REQ_ADD)
        begin
            if (lst_cnt >= SLOTS)
                failed = 1'b1;
            else
            begin
                when_s = secs + (rq.delay_secs[15] ? 32'd0 : {16'd0, rq.delay_secs});
                pos = 0;
                while (pos < lst_cnt && when_s > lst_exp[pos])
                    pos++;
                for (int i = lst_cnt; i > pos; i--)
                begin
                    lst_exp[i] = lst_exp[i - 1];
                    lst_tag[i] = lst_tag[i - 1];
                    lst_act[i] = lst_act[i - 1];
                end
                lst_exp[pos] = when_s;
                lst_tag[pos] = rq.tag;
                lst_act[pos] = rq.has_action;
                lst_cnt++;
            end
        end
        else
            secs = secs + 32'd1;

        if (!failed)
        begin
            while (lst_cnt > 0 && lst_exp[0] <= secs)
            begin
                if (lst_act[0])
                begin
                    r         = '0;
                    r.kind    = stq_pkg::KIND_REPORT;
                    r.tag_res = lst_tag[0];
                    step_out.push_back(r);
                end
                for (int i = 1; i < lst_cnt; i++)
                begin
                    lst_exp[i - 1] = lst_exp[i];
                    lst_tag[i - 1] = lst_tag[i];
                    lst_act[i - 1] = lst_act[i];
                end
                lst_cnt--;
            end
        end

        if (lst_cnt > 0)
            step_out.push_back(closing(failed, 1'b1, lst_exp[0] - secs));
        else
            step_out.push_back(closing(failed, 1'b0, 32'd0));
    endfunction

    function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h actual %h", $time, fname, want, got);
            errors++;
        end
    endfunction

    task automatic sender_gap();
        if (!steady && $urandom_range(99) < 30)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic issue_request(stq_pkg::stq_req_t rq, bit typed, stq_pkg::stq_res_t st);
        in_valid <= 1'b1;
        in_data  <= rq;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_timeouts(rq);
        if (typed)
            awaited_results.push_back(st);
        else
            foreach (step_out[i])
                awaited_results.push_back(step_out[i]);
    endtask

    always @(posedge clk)
    begin
        out_ready <= steady || ($urandom_range(99) >= 30);
    end

    always @(posedge clk)
    begin
        stq_pkg::stq_res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_results.size() == 0)
            begin
                $display("%0t: unexpected result expected none actual %p", $time, out_data);
                errors++;
            end
            else
            begin
                want = awaited_results.pop_front();
                check_field("kind", 32'(want.kind), 32'(out_data.kind));
                check_field("tag_res", want.tag_res, out_data.tag_res);
                check_field("insert_failed", 32'(want.insert_failed),
                            32'(out_data.insert_failed));
                check_field("pending_present", 32'(want.pending_present),
                            32'(out_data.pending_present));
                check_field("next_delay", want.next_delay, out_data.next_delay);
                check_field("last", 32'(want.last), 32'(out_data.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: watchdog expired with %0d results outstanding",
                     $time, awaited_results.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        stq_pkg::stq_req_t rq;
        int                sel;
        int                mode;

        steady      = 1'b0;
        lst_cnt     = 0;
        secs        = '0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;

        // directed: extremes, negative delay, silent drop, ties, full list
        directed_rows.push_back('{mk_req(stq_pkg::REQ_ADD, 16'd5, 32'hFFFF_FFFF, 1'b1), 1'b1,
                                  closing(1'b0, 1'b1, 32'd5)});
        directed_rows.push_back('{mk_req(stq_pkg::REQ_ADD, 16'h8000, 32'h0000_0000, 1'b1),
                                  1'b0, '0});
        directed_rows.push_back('{mk_req(stq_pkg::REQ_ADD, 16'h7FFF, 32'h8000_0000, 1'b0),
                                  1'b0, '0});
        directed_rows.push_back('{mk_req(stq_pkg::REQ_ADD, 16'd0, 32'h0000_1234, 1'b0), 1'b1,
                                  closing(1'b0, 1'b1, 32'd5)});
        directed_rows.push_back('{mk_req(stq_pkg::REQ_TICK, 16'hFFFF, 32'hFFFF_FFFF, 1'b1),
                                  1'b0, '0});
        for (int k = 0; k < 4; k++)
            directed_rows.push_back('{mk_req(stq_pkg::REQ_ADD, 16'd3, 32'hA000_0000 + k, 1'b1),
                                      1'b0, '0});
        directed_rows.push_back('{mk_req(stq_pkg::REQ_ADD, 16'd3, 32'h5555_5555, 1'b0),
                                  1'b0, '0});
        for (int k = 0; k < 9; k++)
            directed_rows.push_back('{mk_req(stq_pkg::REQ_ADD, 16'(10 + k), 32'hB000_0000 + k,
                                             1'(k)), 1'b0, '0});
        // list full: add rejected, time unchanged
        directed_rows.push_back('{mk_req(stq_pkg::REQ_ADD, 16'd1, 32'hDEAD_BEEF, 1'b1), 1'b1,
                                  closing(1'b1, 1'b1, 32'd3)});
        directed_rows.push_back('{mk_req(stq_pkg::REQ_TICK, 16'h0000, 32'h0000_0000, 1'b0),
                                  1'b0, '0});
        directed_rows.push_back('{mk_req(stq_pkg::REQ_ADD, 16'hFFFF, 32'h1111_1111, 1'b1), 1'b1,
                                  closing(1'b1, 1'b1, 32'd2)});
        directed_rows.push_back('{mk_req(stq_pkg::REQ_TICK, 16'h1234, 32'h0F0F_0F0F, 1'b1),
                                  1'b0, '0});
        directed_rows.push_back('{mk_req(stq_pkg::REQ_TICK, 16'h4321, 32'hF0F0_F0F0, 1'b0),
                                  1'b0, '0});
        directed_rows.push_back('{mk_req(stq_pkg::REQ_TICK, 16'h7FFF, 32'h0000_0001, 1'b1),
                                  1'b0, '0});

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            sender_gap();
            issue_request(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].st);
        end

        for (int n = 0; n < RAND_REQS; n++)
        begin
            // hold off until the queue has drained once
            if (n == 240)
            begin
                in_valid <= 1'b0;
                while (awaited_results.size() != 0)
                    @(posedge clk);
            end
            steady = (n >= 150 && n < 250);
            mode   = (n / 40) % 3;
            sel    = $urandom_range(99);
            rq.tag        = $urandom;
            rq.has_action = ($urandom_range(99) < 75);
            rq.delay_secs = 16'($urandom);
            if (sel < (mode == 1 ? 80 : (mode == 0 ? 45 : 20)))
            begin
                rq.req_type = stq_pkg::REQ_ADD;
                sel = $urandom_range(99);
                if (sel < 60)
                    rq.delay_secs = 16'($urandom_range(0, 6));
                else if (sel < 75)
                    rq.delay_secs = 16'($urandom_range(7, 40));
                else if (sel < 88)
                    rq.delay_secs = 16'($urandom_range(32768, 65535));
                else if (sel < 97)
                    rq.delay_secs = 16'($urandom_range(41, 300));
            end
            else
                rq.req_type = stq_pkg::REQ_TICK;
            sender_gap();
            issue_request(rq, 1'b0, '0);
        end
        steady = 1'b0;

        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sorted_timeout_queue_top.f =====
rtl/core/stq_pkg.sv
rtl/core/stq_ctrl.sv
rtl/core/stq_datapath.sv
rtl/core/sorted_timeout_queue_top.sv
test/testbench.sv
